FILE: hw/rtl/btc_pkg.sv
// Shared constants, error codes and helpers for the block to CHS sector read unit.
// Depends on nothing; used by btc_divider and block_to_chs_sector_reads.
`default_nettype none
package btc_pkg;
	localparam int unsigned LBA_W  = 32;
	localparam int unsigned SPT_W  = 6;
	localparam int unsigned HEAD_W = 8;
	localparam int unsigned CYL_W  = 10;
	localparam int unsigned ERR_W  = 3;
	localparam int unsigned IDX_W  = 3;

	localparam logic [LBA_W-1:0] MAX_CYLINDER     = 32'd1023;
	localparam logic [7:0]       FLOPPY_DRIVE_MAX = 8'd26;
	localparam logic [7:0]       HARD_DRIVE_FIRST = 8'h80;
	localparam logic [7:0]       HARD_DRIVE_LAST  = 8'h96;

	localparam logic [1:0] KIND_READAHEAD = 2'd1;

	localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
	localparam logic [ERR_W-1:0] ERR_KIND      = 3'd1;
	localparam logic [ERR_W-1:0] ERR_PARTITION = 3'd2;
	localparam logic [ERR_W-1:0] ERR_CYLINDER  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_DRIVE     = 3'd4;

	localparam logic [IDX_W-1:0] REG_SPT    = 3'd0;
	localparam logic [IDX_W-1:0] REG_HEADS  = 3'd1;
	localparam logic [IDX_W-1:0] REG_HIDDEN = 3'd2;
	localparam logic [IDX_W-1:0] REG_SMALL  = 3'd3;
	localparam logic [IDX_W-1:0] REG_LARGE  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE  = 3'd5;

	function automatic logic drive_ok(input logic [7:0] d);
		drive_ok = (d <= FLOPPY_DRIVE_MAX) || (d >= HARD_DRIVE_FIRST && d <= HARD_DRIVE_LAST);
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/btc_divider.sv
// Pipelined restoring divider, 32-bit dividend, four quotient bits per stage.
// Uses btc_pkg; instantiated twice by block_to_chs_sector_reads.
`default_nettype none
module btc_divider #(
	parameter int unsigned DW = 6,
	parameter int unsigned PW = 6
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic [btc_pkg::LBA_W-1:0] dividend,
	input  wire logic [DW-1:0]            divisor,
	input  wire logic [PW-1:0]            in_pay,
	output logic                          out_valid,
	output logic [btc_pkg::LBA_W-1:0]     quot,
	output logic [DW-1:0]                 rem,
	output logic [PW-1:0]                 out_pay
);
	import btc_pkg::*;

	localparam int unsigned STEP   = 4;
	localparam int unsigned STAGES = LBA_W / STEP;

	logic             v_s   [STAGES];
	logic [LBA_W-1:0] quo_s [STAGES];
	logic [DW-1:0]    rem_s [STAGES];
	logic [PW-1:0]    pay_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [LBA_W-1:0] q_in, q_nx;
		logic [DW-1:0]    r_in, r_nx;
		logic             v_in;
		logic [PW-1:0]    p_in;

		if (k == 0) begin : g_first
			assign q_in = dividend;
			assign r_in = '0;
			assign v_in = in_valid;
			assign p_in = in_pay;
		end else begin : g_next
			assign q_in = quo_s[k-1];
			assign r_in = rem_s[k-1];
			assign v_in = v_s[k-1];
			assign p_in = pay_s[k-1];
		end

		always_comb begin
			logic [DW:0] t;
			q_nx = q_in;
			r_nx = r_in;
			for (int i = 0; i < STEP; i++) begin
				t    = {r_nx, q_nx[LBA_W-1]};
				q_nx = {q_nx[LBA_W-2:0], 1'b0};
				if (t >= {1'b0, divisor}) begin
					t       = t - {1'b0, divisor};
					q_nx[0] = 1'b1;
				end
				r_nx = t[DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= q_nx;
				rem_s[k] <= r_nx;
				pay_s[k] <= p_in;
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign quot      = quo_s[STAGES-1];
	assign rem       = rem_s[STAGES-1];
	assign out_pay   = pay_s[STAGES-1];
endmodule
`default_nettype wire

FILE: hw/rtl/block_to_chs_sector_reads.sv
// Top level: request sequencer, address and bounds stages, two divider pipelines, output stage.
// Depends on btc_pkg and btc_divider.
// A request is taken on the slave side and turned into SECTORS_PER_BLOCK sector reads, one
// issued per cycle while the output is not stalled; a bad-kind request gives a single error read,
// and the next request is taken as the last read issues. Each sector runs through an address stage,
// a bounds stage and two eight-stage dividers (sector/track, then head/cylinder).
// An error result ends its request with tlast; sectors behind it are dropped at the output.
// Configuration writes are always taken (cfg_ready is tied high) and act at once.
`default_nettype none
module block_to_chs_sector_reads #(
	parameter int unsigned SECTORS_PER_BLOCK = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // block_number[31:0]
	input  wire logic [1:0]  s_tuser,   // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // cylinder, head, sector, part_index, drive, error_code, pad
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [btc_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	import btc_pkg::*;

	localparam int unsigned JW = (SECTORS_PER_BLOCK > 1) ? $clog2(SECTORS_PER_BLOCK) : 1;
	localparam int unsigned P1 = JW + ERR_W;
	localparam int unsigned P2 = SPT_W + JW + ERR_W;

	logic [SPT_W-1:0]  spt_q;
	logic [HEAD_W-1:0] heads_q;
	logic [31:0]       hidden_q;
	logic [15:0]       small_q;
	logic [31:0]       large_q;
	logic [7:0]        drive_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q    <= 6'd63;
			heads_q  <= 8'd255;
			hidden_q <= '0;
			small_q  <= '0;
			large_q  <= '0;
			drive_q  <= HARD_DRIVE_FIRST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPT:    spt_q    <= cfg_data[SPT_W-1:0];
				REG_HEADS:  heads_q  <= cfg_data[HEAD_W-1:0];
				REG_HIDDEN: hidden_q <= cfg_data;
				REG_SMALL:  small_q  <= cfg_data[15:0];
				REG_LARGE:  large_q  <= cfg_data;
				REG_DRIVE:  drive_q  <= cfg_data[7:0];
				default:    ;
			endcase
		end
	end

	logic out_v_q;
	logic en;
	assign en = !out_v_q || m_tready;

	// request sequencer
	logic          req_v_q;
	logic [31:0]   blk_q;
	logic [1:0]    kind_q;
	logic [JW-1:0] j_q;
	logic          bad, done, issue, accept;

	assign bad      = kind_q > KIND_READAHEAD;
	assign done     = bad || (j_q == JW'(SECTORS_PER_BLOCK - 1));
	assign issue    = req_v_q && en;
	assign s_tready = !req_v_q || (en && done);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_q <= 1'b0;
			j_q     <= '0;
		end else if (accept) begin
			req_v_q <= 1'b1;
			j_q     <= '0;
		end else if (issue && done) begin
			req_v_q <= 1'b0;
		end else if (issue) begin
			j_q <= j_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q  <= s_tdata;
			kind_q <= s_tuser;
		end
	end

	// stage 1: linear address
	logic          v_s1;
	logic [31:0]   lba_s1;
	logic [JW-1:0] j_s1;
	logic          bad_s1;
	logic [31:0]   lba_c;

	assign lba_c = 32'(blk_q * 32'(SECTORS_PER_BLOCK)) + hidden_q + 32'(j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lba_s1 <= lba_c;
			j_s1   <= j_q;
			bad_s1 <= bad;
		end
	end

	// stage 2: bounds and drive checks
	logic          v_s2;
	logic [31:0]   lba_s2;
	logic [JW-1:0] j_s2;
	logic [ERR_W-1:0] err_s2;
	logic          outside;
	logic [32:0]   small_lim, large_lim;
	logic [ERR_W-1:0] err_c;

	assign small_lim = {17'd0, small_q} + {1'b0, hidden_q};
	assign large_lim = {1'b0, large_q} + {1'b0, hidden_q};
	assign outside = (small_q != '0 && {1'b0, lba_s1} > small_lim) ||
	                 (large_q != '0 && {1'b0, lba_s1} > large_lim) ||
	                 (hidden_q != '0 && lba_s1 < hidden_q);

	always_comb begin
		if (bad_s1)
			err_c = ERR_KIND;
		else if (outside)
			err_c = ERR_PARTITION;
		else if (!drive_ok(drive_q))
			err_c = ERR_DRIVE;
		else
			err_c = ERR_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lba_s2 <= lba_s1;
			j_s2   <= j_s1;
			err_s2 <= err_c;
		end
	end

	// dividers
	logic [SPT_W-1:0]  spt_eff;
	logic [HEAD_W-1:0] heads_eff;
	assign spt_eff   = (spt_q == '0) ? SPT_W'(1) : spt_q;
	assign heads_eff = (heads_q == '0) ? HEAD_W'(1) : heads_q;

	logic          d1_v;
	logic [31:0]   tracks;
	logic [SPT_W-1:0] sec_rem;
	logic [P1-1:0] d1_pay;

	btc_divider #(.DW(SPT_W), .PW(P1)) u_div_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.dividend  (lba_s2),
		.divisor   (spt_eff),
		.in_pay    ({j_s2, err_s2}),
		.out_valid (d1_v),
		.quot      (tracks),
		.rem       (sec_rem),
		.out_pay   (d1_pay)
	);

	logic          d2_v;
	logic [31:0]   cyl_full;
	logic [HEAD_W-1:0] head_rem;
	logic [P2-1:0] d2_pay;

	btc_divider #(.DW(HEAD_W), .PW(P2)) u_div_cyl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d1_v),
		.dividend  (tracks),
		.divisor   (heads_eff),
		.in_pay    ({sec_rem + SPT_W'(1), d1_pay}),
		.out_valid (d2_v),
		.quot      (cyl_full),
		.rem       (head_rem),
		.out_pay   (d2_pay)
	);

	// output stage
	logic [SPT_W-1:0] f_sec;
	logic [JW-1:0]    f_j;
	logic [ERR_W-1:0] f_err_in, f_err;
	logic             f_first, pass, kill_q;

	assign {f_sec, f_j, f_err_in} = d2_pay;
	assign f_err   = (f_err_in != ERR_OK) ? f_err_in :
	                 (cyl_full > MAX_CYLINDER) ? ERR_CYLINDER : ERR_OK;
	assign f_first = (f_j == '0);
	assign pass    = d2_v && (f_first || !kill_q);

	logic [CYL_W-1:0]  cyl_q;
	logic [HEAD_W-1:0] head_q;
	logic [SPT_W-1:0]  sec_q;
	logic [2:0]        part_q;
	logic [7:0]        drv_q;
	logic [ERR_W-1:0]  err_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			kill_q  <= 1'b0;
		end else if (en) begin
			out_v_q <= pass;
			if (d2_v)
				kill_q <= (f_first ? 1'b0 : kill_q) | (f_err != ERR_OK);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cyl_q  <= (f_err == ERR_OK) ? cyl_full[CYL_W-1:0] : '0;
			head_q <= (f_err == ERR_OK) ? head_rem : '0;
			sec_q  <= (f_err == ERR_OK) ? f_sec : '0;
			part_q <= 3'(f_j);
			drv_q  <= drive_q;
			err_q  <= f_err;
			last_q <= (f_err != ERR_OK) || (f_j == JW'(SECTORS_PER_BLOCK - 1));
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, err_q, drv_q, part_q, sec_q, head_q, cyl_q};
	assign m_tlast  = last_q;

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err_q != ERR_OK |-> m_tlast)
		else $error("error result without tlast");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err_q != ERR_OK |-> cyl_q == '0 && head_q == '0 && sec_q == '0)
		else $error("error result carries an address");
	a_ok_sector: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err_q == ERR_OK |-> sec_q != '0)
		else $error("good result with sector zero");
	a_hold_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_v_q && !en |-> !s_tready)
		else $error("request taken while sequencer stalled");
endmodule
`default_nettype wire

FILE: tb/sv/tb_block_to_chs_sector_reads.sv
// Self-checking bench for block_to_chs_sector_reads: directed and random block read
// requests, each predicted into its sector read commands and compared at the output.
// Depends on btc_pkg and the block_to_chs_sector_reads RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_block_to_chs_sector_reads;
	import btc_pkg::*;

	localparam int unsigned SPB     = 2;
	localparam int unsigned LATENCY = 40;

	typedef struct packed {
		logic [9:0]  cylinder;
		logic [7:0]  head;
		logic [5:0]  sector;
		logic [2:0]  part_index;
		logic [7:0]  drive;
		logic [2:0]  error_code;
		logic        last;
	} sector_cmd_t;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, m_tvalid, m_tready, m_tlast, cfg_valid, cfg_ready;
	logic [31:0] s_tdata, cfg_data;
	logic [1:0]  s_tuser;
	logic [39:0] m_tdata;
	logic [IDX_W-1:0] cfg_index;

	logic [5:0]  spt_r;
	logic [7:0]  heads_r;
	logic [31:0] hidden_r;
	logic [15:0] small_r;
	logic [31:0] large_r;
	logic [7:0]  drive_r;

	sector_cmd_t pending_cmds[$];
	int          mismatches;
	int          cmds_seen;
	int          requests_sent;
	bit          quiet_send;
	bit          quiet_recv;
	int          recv_hold;

	block_to_chs_sector_reads #(.SECTORS_PER_BLOCK(SPB)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		mismatches++;
	endtask

	function automatic sector_cmd_t err_cmd(input logic [2:0] part, input logic [2:0] code);
		sector_cmd_t c;
		c = '0;
		c.part_index = part;
		c.drive = drive_r;
		c.error_code = code;
		c.last = 1'b1;
		return c;
	endfunction

	task automatic expand_request(input logic [1:0] kind, input logic [31:0] blk);
		logic [63:0] spt, heads, lba, tracks, cyl, hid;
		logic [31:0] base;
		bit          outside;
		sector_cmd_t c;
		spt = (spt_r == 0) ? 64'd1 : 64'(spt_r);
		heads = (heads_r == 0) ? 64'd1 : 64'(heads_r);
		hid = 64'(hidden_r);
		if (kind > KIND_READAHEAD) begin
			pending_cmds.push_back(err_cmd(3'd0, ERR_KIND));
			return;
		end
		base = blk * SPB + hidden_r;
		for (int j = 0; j < SPB; j++) begin
			lba = 64'(32'(base + j));
			outside = (small_r != 0 && lba > 64'(small_r) + hid) ||
				(large_r != 0 && lba > 64'(large_r) + hid) ||
				(hidden_r != 0 && lba < hid);
			if (outside) begin
				pending_cmds.push_back(err_cmd(3'(j), ERR_PARTITION));
				return;
			end
			if (!(drive_r <= 8'd26 || (drive_r >= 8'h80 && drive_r <= 8'h96))) begin
				pending_cmds.push_back(err_cmd(3'(j), ERR_DRIVE));
				return;
			end
			tracks = lba / spt;
			cyl = tracks / heads;
			if (cyl > 64'd1023) begin
				pending_cmds.push_back(err_cmd(3'(j), ERR_CYLINDER));
				return;
			end
			c.cylinder = cyl[9:0];
			c.head = 8'(tracks % heads);
			c.sector = 6'(lba % spt + 1);
			c.part_index = 3'(j);
			c.drive = drive_r;
			c.error_code = ERR_OK;
			c.last = (j == SPB - 1);
			pending_cmds.push_back(c);
		end
	endtask

	// one request transfer, with random idle cycles before it unless quiet_send is set; tvalid stays up
	// after the transfer until the next idle cycle or drain
	task automatic send_request(input logic [1:0] kind, input logic [31:0] blk);
		while (!quiet_send && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= blk;
		expand_request(kind, blk);
		requests_sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	always @(posedge clk) begin
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet_recv || ($urandom_range(99) >= 28);
		end
		if (arst_n && m_tvalid && m_tready) begin
			sector_cmd_t want;
			cmds_seen++;
			if (pending_cmds.size() == 0) begin
				report("unexpected transfer", 64'(m_tdata), 64'd0);
			end else begin
				want = pending_cmds.pop_front();
				if (m_tdata[9:0] != want.cylinder)
					report("cylinder", 64'(m_tdata[9:0]), 64'(want.cylinder));
				if (m_tdata[17:10] != want.head)
					report("head", 64'(m_tdata[17:10]), 64'(want.head));
				if (m_tdata[23:18] != want.sector)
					report("sector", 64'(m_tdata[23:18]), 64'(want.sector));
				if (m_tdata[26:24] != want.part_index)
					report("part_index", 64'(m_tdata[26:24]), 64'(want.part_index));
				if (m_tdata[34:27] != want.drive)
					report("drive", 64'(m_tdata[34:27]), 64'(want.drive));
				if (m_tdata[37:35] != want.error_code)
					report("error_code", 64'(m_tdata[37:35]), 64'(want.error_code));
				if (m_tlast != want.last) report("last", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SPT:    spt_r <= val[5:0];
			REG_HEADS:  heads_r <= val[7:0];
			REG_HIDDEN: hidden_r <= val;
			REG_SMALL:  small_r <= val[15:0];
			REG_LARGE:  large_r <= val;
			REG_DRIVE:  drive_r <= val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic setup(input logic [5:0] spt, input logic [7:0] hd, input logic [31:0] hid,
			input logic [15:0] sm, input logic [31:0] lg, input logic [7:0] drv);
		drain();
		write_reg(REG_SPT, 32'(spt));
		write_reg(REG_HEADS, 32'(hd));
		write_reg(REG_HIDDEN, hid);
		write_reg(REG_SMALL, 32'(sm));
		write_reg(REG_LARGE, lg);
		write_reg(REG_DRIVE, 32'(drv));
	endtask

	task automatic test_reset_geometry();
		send_request(2'd0, 32'd0);
		send_request(2'd1, 32'd1);
		send_request(2'd0, 32'd500);
		send_request(2'd0, 32'd8_000_000);
		send_request(2'd1, 32'hFFFF_FFFF);
	endtask

	task automatic test_bad_kind();
		send_request(2'd2, 32'd7);
		send_request(2'd3, 32'hFFFF_FFFF);
	endtask

	task automatic test_partition_bounds();
		setup(6'd17, 8'd4, 32'd100, 16'd20, 32'd0, 8'h80);
		send_request(2'd0, 32'd9);
		send_request(2'd0, 32'd10);
		send_request(2'd0, 32'd11);
		setup(6'd17, 8'd4, 32'd100, 16'd0, 32'd31, 8'h80);
		send_request(2'd1, 32'd15);
		send_request(2'd1, 32'd16);
		setup(6'd63, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd0);
		send_request(2'd0, 32'd0);
		send_request(2'd0, 32'h7FFF_FFFF);
	endtask

	task automatic test_drive_codes();
		for (int k = 0; k < 6; k++) begin
			logic [7:0] codes[6] = '{8'd26, 8'd27, 8'h7F, 8'h96, 8'h97, 8'hFF};
			setup(6'd63, 8'd255, 32'd0, 16'd0, 32'd0, codes[k]);
			send_request(2'd0, 32'd3);
		end
	endtask

	task automatic test_zero_divisors();
		setup(6'd0, 8'd0, 32'd0, 16'd0, 32'd0, 8'd5);
		send_request(2'd0, 32'd100);
		send_request(2'd0, 32'd511);
		send_request(2'd0, 32'd512);
		setup(6'd1, 8'd1, 32'd0, 16'd0, 32'd0, 8'd5);
		send_request(2'd1, 32'd1000);
	endtask

	task automatic test_backpressure();
		setup(6'd63, 8'd16, 32'd0, 16'd0, 32'd0, 8'h81);
		quiet_send = 1;
		recv_hold = 400;
		for (int k = 0; k < 30; k++) send_request(2'($urandom_range(1)), $urandom_range(60000));
		quiet_send = 0;
		drain();
	endtask

	task automatic test_random(input int count);
		int n;
		logic [1:0] kind;
		logic [31:0] blk;
		for (int phase = 0; phase < 5; phase++) begin
			setup(6'($urandom_range(63, 1)), 8'($urandom_range(255, 1)),
				($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(5000)),
				($urandom_range(2) == 0) ? 16'($urandom) : 16'd0,
				($urandom_range(2) == 0) ? $urandom : 32'd0,
				($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(8'h96, 8'h80)));
			quiet_send = (phase == 2);
			quiet_recv = (phase == 2);
			n = count / 5;
			for (int k = 0; k < n; k++) begin
				kind = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
				case ($urandom_range(3))
					0: blk = $urandom;
					1: blk = 32'($urandom_range(40000));
					2: blk = 32'(small_r) / SPB + 32'($urandom_range(2)) - 1;
					default: blk = 32'($urandom_range(600000));
				endcase
				send_request(kind, blk);
			end
			quiet_send = 0;
			quiet_recv = 0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		spt_r = 6'd63; heads_r = 8'd255; hidden_r = '0; small_r = '0; large_r = '0;
		drive_r = 8'h80;
		mismatches = 0; cmds_seen = 0; requests_sent = 0;
		quiet_send = 0; quiet_recv = 0; recv_hold = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_bad_kind();
		test_partition_bounds();
		test_drive_codes();
		test_zero_divisors();
		test_backpressure();
		test_random(250);
		drain();
		$display("%0d requests gave %0d sector commands over bounds, drives, kinds and",
			requests_sent, cmds_seen);
		$display("geometry extremes, with an output stall long enough to fill the pipeline");
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
